FILE: design/lffa_pkg.sv
`timescale 1ns / 1ps

package lffa_pkg;

    // item and register field widths
    localparam int LED_W    = 3;
    localparam int RAND_W   = 15;
    localparam int CH_W     = 7;
    localparam int POS_W    = 8;
    localparam int HUE_W    = 8;
    localparam int AMODE_W  = 2;
    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 5;
    localparam int REG_IDX_W = 3;

    // register map, word index on paddr[4:2]
    localparam logic [REG_IDX_W-1:0] REG_ANIM_MODE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ON_TICKS   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFF_TICKS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BASE_HUE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HUE_SPREAD = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_HUE = 3'd5;

    // animation modes and item kinds
    localparam logic [AMODE_W-1:0] MODE_FLASH   = 2'd0;
    localparam logic [AMODE_W-1:0] MODE_FADE    = 2'd1;
    localparam logic               ITEM_TICK    = 1'b0;
    localparam logic               ITEM_RESTART = 1'b1;
    localparam logic [AMODE_W-1:0] ANIM_MODE_RST = MODE_FADE;

    // colour wheel segment bounds
    localparam logic [HUE_W-1:0] WHEEL_SEG_LAST  = 8'd84;
    localparam logic [HUE_W-1:0] WHEEL_SEG       = 8'd85;
    localparam logic [HUE_W-1:0] WHEEL_MID_LAST  = 8'd170;
    localparam logic [HUE_W-1:0] WHEEL_TOP_FIRST = 8'd171;

    // second hue is picked when it is nonzero and the low byte of the random value is below this
    localparam logic [7:0] PICK_LIMIT = 8'd127;

    // shared divider: two quotient bits a cycle
    localparam int DIVIDEND_W   = 16;
    localparam int DIVISOR_W    = 9;
    localparam int DIV_BITS     = 2;
    localparam int DIV_CYCLES   = DIVIDEND_W / DIV_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_rgb;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] len;
        t_rgb             base;
        t_rgb             shown;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIV_R,
        S_DIV_G,
        S_DIV_B,
        S_STEP,
        S_LEN,
        S_HUE,
        S_START,
        S_WB,
        S_OUT
    } t_state;

    // three-segment hue wheel
    function automatic t_rgb wheel(input logic [HUE_W-1:0] hue);
        t_rgb             c;
        logic [HUE_W-1:0] t;
        c = '0;
        if (hue <= WHEEL_SEG_LAST) begin
            t   = WHEEL_SEG_LAST - hue;
            c.r = t[CH_W-1:0];
            c.g = hue[CH_W-1:0];
        end else if (hue <= WHEEL_MID_LAST) begin
            t   = (hue == WHEEL_MID_LAST) ? '0 : hue - WHEEL_SEG;
            c.g = CH_W'(WHEEL_SEG_LAST - t);
            c.b = t[CH_W-1:0];
        end else begin
            t   = hue - WHEEL_TOP_FIRST;
            c.r = t[CH_W-1:0];
            c.b = CH_W'(WHEEL_SEG - t);
        end
        return c;
    endfunction

endpackage

FILE: design/lffa_ram.sv
`timescale 1ns / 1ps

module lffa_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/lffa_div.sv
`timescale 1ns / 1ps

module lffa_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lffa_pkg::t_div_req  i_req,
    output lffa_pkg::t_div_rsp  o_rsp
);

    import lffa_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVIDEND_W-1:0] n_quo;
    logic [DIVISOR_W-1:0]  n_rem;

    // restoring division, two bits per cycle
    always_comb begin
        logic [DIVISOR_W:0] t;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < DIV_BITS; k++) begin
            t     = {n_rem, n_quo[DIVIDEND_W-1]};
            n_quo = {n_quo[DIVIDEND_W-2:0], 1'b0};
            if (t >= {1'b0, r_dvs}) begin
                n_rem    = DIVISOR_W'(t - {1'b0, r_dvs});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = t[DIVISOR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

FILE: design/led_flash_fade_animator_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake                    payload
// -------   ---------  ---------------------------  -----------------------------------------
// in        sink       i_in_valid / o_in_ready      i_mode, i_led_index, i_rand_length,
//                                                   i_rand_hue, i_rand_pick, i_rand_start
// out       source     o_out_valid / i_out_ready    o_led_out, o_red, o_green, o_blue
// config    APB slave  psel, penable, pwrite        paddr, pwdata, prdata, pready (always high)
//
// one item at a time; a tick in flash or hold mode needs no division, a lit tick in fade mode
// takes three divider passes, a tick that starts a new cycle adds up to two more (length and
// hue), a restart takes up to three (length, hue, start), and an absent led goes straight out
// reset is synchronous, active low; it clears control, registers and per-led valid bits,
// an led whose entry was never written reads as all zero
// the next item is accepted once the previous result has moved to the output register;
// while that register is full and not taken, a finished item waits and holds the input off

module led_flash_fade_animator_top #(
    parameter int LED_COUNT = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_mode,
    input  logic [lffa_pkg::LED_W-1:0]     i_led_index,
    input  logic [lffa_pkg::RAND_W-1:0]    i_rand_length,
    input  logic [lffa_pkg::RAND_W-1:0]    i_rand_hue,
    input  logic [lffa_pkg::RAND_W-1:0]    i_rand_pick,
    input  logic [lffa_pkg::RAND_W-1:0]    i_rand_start,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lffa_pkg::LED_W-1:0]     o_led_out,
    output logic [lffa_pkg::CH_W-1:0]      o_red,
    output logic [lffa_pkg::CH_W-1:0]      o_green,
    output logic [lffa_pkg::CH_W-1:0]      o_blue,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lffa_pkg::PADDR_W-1:0]   paddr,
    input  logic [lffa_pkg::APB_DW-1:0]    pwdata,
    output logic [lffa_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    import lffa_pkg::*;

    localparam int ADDR_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CNT_BIT = $clog2(LED_COUNT + 1);
    localparam int CMP_W   = (CNT_BIT > LED_W) ? CNT_BIT : LED_W;

    // configuration registers
    logic [AMODE_W-1:0] r_anim_mode;
    logic [POS_W-1:0]   r_on_ticks;
    logic [POS_W-1:0]   r_off_ticks;
    logic [HUE_W-1:0]   r_base_hue;
    logic [HUE_W-1:0]   r_hue_spread;
    logic [HUE_W-1:0]   r_second_hue;

    // sequencer
    t_state             r_state;
    t_state             n_state;
    logic               r_launched;
    logic               n_launched;
    logic [LED_COUNT-1:0] r_valid;

    // item being worked on
    logic               r_mode;
    logic [LED_W-1:0]   r_idx;
    logic [RAND_W-1:0]  r_rl;
    logic [RAND_W-1:0]  r_rh;
    logic [RAND_W-1:0]  r_rp;
    logic [RAND_W-1:0]  r_rs;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_len;
    t_rgb               r_base;
    t_rgb               r_shown;
    logic [CH_W-1:0]    r_num;
    logic [CH_W-1:0]    r_half;

    // output register
    logic               r_out_valid;
    logic [LED_W-1:0]   r_out_led;
    t_rgb               r_out_colour;

    // glue
    logic               w_cfg_wr;
    logic [REG_IDX_W-1:0] w_cfg_idx;
    logic               w_in_acc;
    logic               w_in_range;
    logic               w_out_free;
    logic [ADDR_W-1:0]  w_addr;
    logic [ENTRY_W-1:0] w_ram_rdata;
    logic               w_ram_we;
    t_entry             w_entry;
    t_entry             w_wb_entry;
    logic [CH_W-1:0]    w_half;
    logic [POS_W-1:0]   w_rd_pos;
    logic               w_fade_black;
    logic [CH_W-1:0]    w_num;
    logic [POS_W-1:0]   w_len0;
    logic [POS_W-1:0]   w_pos_inc;
    logic [HUE_W-1:0]   w_hue_off;
    logic [HUE_W-1:0]   w_hue;
    logic [CH_W-1:0]    w_ch;
    logic [2*CH_W-1:0]  w_prod;
    logic               w_div_state;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    // ---------------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anim_mode  <= ANIM_MODE_RST;
            r_on_ticks   <= '0;
            r_off_ticks  <= '0;
            r_base_hue   <= '0;
            r_hue_spread <= '0;
            r_second_hue <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_ANIM_MODE:  r_anim_mode  <= pwdata[AMODE_W-1:0];
                REG_ON_TICKS:   r_on_ticks   <= pwdata[POS_W-1:0];
                REG_OFF_TICKS:  r_off_ticks  <= pwdata[POS_W-1:0];
                REG_BASE_HUE:   r_base_hue   <= pwdata[HUE_W-1:0];
                REG_HUE_SPREAD: r_hue_spread <= pwdata[HUE_W-1:0];
                REG_SECOND_HUE: r_second_hue <= pwdata[HUE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_ANIM_MODE:  prdata = APB_DW'(r_anim_mode);
            REG_ON_TICKS:   prdata = APB_DW'(r_on_ticks);
            REG_OFF_TICKS:  prdata = APB_DW'(r_off_ticks);
            REG_BASE_HUE:   prdata = APB_DW'(r_base_hue);
            REG_HUE_SPREAD: prdata = APB_DW'(r_hue_spread);
            REG_SECOND_HUE: prdata = APB_DW'(r_second_hue);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // per-led state memory: position, length, base and shown colour
    // ---------------------------------------------------------------------
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_in_range = CMP_W'(i_led_index) < CMP_W'(LED_COUNT);
    assign w_addr     = (r_state == S_IDLE) ? ADDR_W'(i_led_index) : ADDR_W'(r_idx);

    assign w_wb_entry.pos   = r_pos;
    assign w_wb_entry.len   = r_len;
    assign w_wb_entry.base  = r_base;
    assign w_wb_entry.shown = r_shown;

    lffa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LED_COUNT)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_addr),
        .i_wdata (w_wb_entry),
        .i_re    (w_in_acc),
        .i_raddr (w_addr),
        .o_rdata (w_ram_rdata)
    );

    // an led never written back reads as its reset value
    assign w_entry = r_valid[w_addr] ? t_entry'(w_ram_rdata) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_ram_we) begin
            r_valid[w_addr] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // shared divider: fade scaling, and the length, hue and start modulos that set up a new cycle
    // ---------------------------------------------------------------------
    lffa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---------------------------------------------------------------------
    // datapath helpers
    // ---------------------------------------------------------------------
    assign w_half       = r_on_ticks[POS_W-1:1];
    assign w_rd_pos     = w_entry.pos;
    // black when the ramp has no width or the lit portion is over
    assign w_fade_black = (w_half == '0) || (w_rd_pos >= r_on_ticks);
    // rising half counts up, falling half counts back down
    assign w_num        = (w_rd_pos < {1'b0, w_half}) ? w_rd_pos[CH_W-1:0]
                                                      : CH_W'({w_half, 1'b0} - w_rd_pos);
    assign w_len0       = r_on_ticks + r_off_ticks;
    assign w_pos_inc    = r_pos + 1'b1;
    assign w_hue_off    = r_base_hue + w_div_rsp.remainder[HUE_W-1:0];
    assign w_hue        = ((r_second_hue != '0) && (r_rp[7:0] < PICK_LIMIT)) ? r_second_hue
                                                                             : w_hue_off;

    always_comb begin
        case (r_state)
            S_DIV_R: w_ch = r_base.r;
            S_DIV_G: w_ch = r_base.g;
            default: w_ch = r_base.b;
        endcase
    end

    assign w_prod = w_ch * r_num;

    // ---------------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_in_range ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                if (r_mode == ITEM_RESTART) begin
                    n_state = S_LEN;
                end else if ((r_anim_mode == MODE_FADE) && !w_fade_black) begin
                    n_state = S_DIV_R;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DIV_R: begin
                if (w_div_rsp.done) n_state = S_DIV_G;
            end
            S_DIV_G: begin
                if (w_div_rsp.done) n_state = S_DIV_B;
            end
            S_DIV_B: begin
                if (w_div_rsp.done) n_state = S_STEP;
            end
            S_STEP: begin
                n_state = (w_pos_inc >= r_len) ? S_LEN : S_WB;
            end
            S_LEN: begin
                if ((w_len0 == '0) || w_div_rsp.done) n_state = S_HUE;
            end
            S_HUE: begin
                if (w_div_rsp.done) begin
                    n_state = (r_mode == ITEM_RESTART) ? S_START : S_WB;
                end
            end
            S_START: begin
                if ((r_len == '0) || w_div_rsp.done) n_state = S_WB;
            end
            S_WB: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // sequencer: outputs
    // ---------------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        w_ram_we   = 1'b0;
        w_div_state = 1'b0;
        w_div_req.dividend = DIVIDEND_W'(w_prod);
        w_div_req.divisor  = DIVISOR_W'(r_half);
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_DIV_R, S_DIV_G, S_DIV_B: w_div_state = 1'b1;
            S_LEN: begin
                w_div_state        = (w_len0 != '0);
                w_div_req.dividend = DIVIDEND_W'(r_rl);
                w_div_req.divisor  = DIVISOR_W'(w_len0);
            end
            S_HUE: begin
                w_div_state        = 1'b1;
                w_div_req.dividend = DIVIDEND_W'(r_rh);
                w_div_req.divisor  = DIVISOR_W'(r_hue_spread) + 1'b1;
            end
            S_START: begin
                w_div_state        = (r_len != '0);
                w_div_req.dividend = DIVIDEND_W'(r_rs);
                w_div_req.divisor  = DIVISOR_W'(r_len);
            end
            S_WB: w_ram_we = 1'b1;
            default: ;
        endcase
        w_div_req.start = w_div_state & ~r_launched;
        if (w_div_req.start) begin
            n_launched = 1'b1;
        end else if (w_div_rsp.done) begin
            n_launched = 1'b0;
        end else begin
            n_launched = r_launched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launched <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_launched <= n_launched;
        end
    end

    // ---------------------------------------------------------------------
    // working registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_mode  <= i_mode;
                    r_idx   <= i_led_index;
                    r_rl    <= i_rand_length;
                    r_rh    <= i_rand_hue;
                    r_rp    <= i_rand_pick;
                    r_rs    <= i_rand_start;
                    r_shown <= '0;
                end
            end
            S_READ: begin
                r_pos  <= w_entry.pos;
                r_len  <= w_entry.len;
                r_base <= w_entry.base;
                r_num  <= w_num;
                r_half <= w_half;
                if (r_mode == ITEM_TICK && r_anim_mode == MODE_FLASH) begin
                    r_shown <= (w_rd_pos >= r_on_ticks) ? '0 : w_entry.base;
                end else if (r_mode == ITEM_TICK && r_anim_mode == MODE_FADE
                             && w_fade_black) begin
                    r_shown <= '0;
                end else begin
                    r_shown <= w_entry.shown;
                end
            end
            S_DIV_R: begin
                if (w_div_rsp.done) r_shown.r <= w_div_rsp.quotient[CH_W-1:0];
            end
            S_DIV_G: begin
                if (w_div_rsp.done) r_shown.g <= w_div_rsp.quotient[CH_W-1:0];
            end
            S_DIV_B: begin
                if (w_div_rsp.done) r_shown.b <= w_div_rsp.quotient[CH_W-1:0];
            end
            S_STEP: begin
                r_pos <= w_pos_inc;
            end
            S_LEN: begin
                r_pos <= '0;
                if (w_len0 == '0) begin
                    r_len <= '0;
                end else if (w_div_rsp.done) begin
                    r_len <= w_len0 + w_div_rsp.remainder[POS_W-1:0];
                end
            end
            S_HUE: begin
                if (w_div_rsp.done) r_base <= wheel(w_hue);
            end
            S_START: begin
                if (r_len == '0) begin
                    r_pos <= '0;
                end else if (w_div_rsp.done) begin
                    r_pos <= w_div_rsp.remainder[POS_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    assign w_out_free = ~r_out_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_led    <= r_idx;
            r_out_colour <= r_shown;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_out   = r_out_led;
    assign o_red       = r_out_colour.r;
    assign o_green     = r_out_colour.g;
    assign o_blue      = r_out_colour.b;

`ifndef SYNTHESIS
    // an accepted item goes to the memory read, or straight out when the led is absent
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_READ || r_state == S_OUT))
        else $error("unexpected state after item accept");

    // a division is only launched on an idle divider
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> (!w_div_rsp.busy && !w_div_rsp.done))
        else $error("division launched while divider in use");

    // only leds that exist are ever written back
    a_wb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (CMP_W'(r_idx) < CMP_W'(LED_COUNT)))
        else $error("write-back to an absent led");

    // colour levels stay on the wheel range
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_red <= CH_W'(WHEEL_SEG) && o_green <= CH_W'(WHEEL_SEG)
                         && o_blue <= CH_W'(WHEEL_SEG)))
        else $error("colour level above range");

    // an absent led reports black
    a_absent_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (CMP_W'(o_led_out) >= CMP_W'(LED_COUNT)))
            |-> (o_red == '0 && o_green == '0 && o_blue == '0))
        else $error("absent led not black");
`endif

endmodule
